FILE: rtl/assert_macros.svh
// Assertion macros shared by the heap select RTL.
// Depends on nothing; users must have clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cond implies prop in the same cycle.
`define BMHS_ASSERT_IMPL(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Check that cond implies prop in the next cycle.
`define BMHS_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

FILE: rtl/bmhs_pkg.sv
// Shared types and constants for the binary max-heap select unit.
// Used by binary_max_heap_select_unit and bmhs_sift; depends on nothing.
package bmhs_pkg;

  localparam int DEPTH_DEFAULT = 1024;
  localparam int VALUE_W       = 32;
  localparam int ENTRY_W       = 11;

  typedef logic signed [VALUE_W-1:0] value_t;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_BUILD  = 2'd1,
    CMD_OFFER  = 2'd2,
    CMD_DELETE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

endpackage

FILE: rtl/binary_max_heap_select_unit.sv
// Binary max-heap select unit: load, build, offer and delete on a RAM heap.
// Load writes the value into the next free slot. Offer sifts from the root; delete first reads
// the last slot (S_LAST), then sifts it from the root. Each level of a sift is a read and a compare.
// Build sifts each parent in turn, last parent first. One transaction in flight; the next is
// accepted once the result sits in the output register. Reset (sync, high) empties the heap.
// Depends on bmhs_pkg, bmhs_ram, bmhs_sift and assert_macros.svh.
`include "assert_macros.svh"

module binary_max_heap_select_unit #(
  parameter int DEPTH = bmhs_pkg::DEPTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      cmd,
  input  logic signed [bmhs_pkg::VALUE_W-1:0] value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [bmhs_pkg::VALUE_W-1:0] top_value,
  output logic signed [bmhs_pkg::VALUE_W-1:0] removed_value,
  output logic [bmhs_pkg::ENTRY_W-1:0]    entry_count,
  output logic                            offer_taken,
  output logic [1:0]                      status
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_LAST, S_BLD_RD, S_BLD_USE, S_SIFT, S_FINISH
  } state_t;

  state_t             state;
  logic [CW-1:0]      count;
  bmhs_pkg::value_t   root;
  bmhs_pkg::cmd_t     cmd_q;
  bmhs_pkg::value_t   removed_q;
  logic               taken_q;
  bmhs_pkg::status_t  status_q;
  logic [AW-1:0]      bp;

  bmhs_pkg::value_t   top_out;
  bmhs_pkg::value_t   removed_out;
  logic [bmhs_pkg::ENTRY_W-1:0] count_out;
  logic               taken_out;
  bmhs_pkg::status_t  status_out;

  bmhs_pkg::cmd_t     cmd_in;
  logic               in_fire;
  logic               full;
  logic               empty;
  logic [CW-1:0]      cnt_dec;
  logic [CW-1:0]      cnt_half;
  logic               offer_ok;
  logic               load_ok_fire;

  logic               top_we;
  logic [AW-1:0]      top_raddr;

  logic               sift_start;
  logic [AW-1:0]      sift_pos;
  bmhs_pkg::value_t   sift_val;
  logic               sift_done;
  logic               eng_we;
  logic [AW-1:0]      eng_waddr;
  bmhs_pkg::value_t   eng_wdata;
  logic [AW-1:0]      eng_raddr_a;
  logic [AW-1:0]      eng_raddr_b;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  bmhs_pkg::value_t   ram_wdata;
  logic [AW-1:0]      ram_raddr_a;
  bmhs_pkg::value_t   ram_rdata_a;
  bmhs_pkg::value_t   ram_rdata_b;

  // Decode the incoming transaction
  assign cmd_in       = bmhs_pkg::cmd_t'(cmd);
  assign in_ready     = (state == S_IDLE);
  assign in_fire      = in_valid && in_ready;
  assign full         = (count == CW'(DEPTH));
  assign empty        = (count == '0);
  assign cnt_dec      = count - CW'(1);
  assign cnt_half     = count >> 1;
  assign offer_ok     = !empty && (value <= root);
  assign load_ok_fire = in_fire && (cmd_in == bmhs_pkg::CMD_LOAD) && !full;

  // Direct RAM accesses from the command sequencer
  assign top_we    = load_ok_fire;
  assign top_raddr = (state == S_BLD_RD) ? (bp - AW'(1)) : cnt_dec[AW-1:0];

  // Launch a sift for offer, delete refill, or one build parent
  assign sift_start = (in_fire && (cmd_in == bmhs_pkg::CMD_OFFER) && offer_ok) ||
                      (state == S_LAST) || (state == S_BLD_USE);
  assign sift_pos   = (state == S_BLD_USE) ? bp : '0;
  assign sift_val   = (state == S_IDLE) ? value : ram_rdata_a;

  // Hand the RAM to the sift engine while it runs
  assign ram_we      = (state == S_SIFT) ? eng_we : top_we;
  assign ram_waddr   = (state == S_SIFT) ? eng_waddr : count[AW-1:0];
  assign ram_wdata   = (state == S_SIFT) ? eng_wdata : value;
  assign ram_raddr_a = (state == S_SIFT) ? eng_raddr_a : top_raddr;

  bmhs_ram #(
    .WIDTH (bmhs_pkg::VALUE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_raddr_a),
    .raddr_b (eng_raddr_b),
    .rdata_a (ram_rdata_a),
    .rdata_b (ram_rdata_b)
  );

  bmhs_sift #(
    .DEPTH (DEPTH)
  ) u_sift (
    .clk       (clk),
    .rst       (rst),
    .start     (sift_start),
    .start_pos (sift_pos),
    .start_val (sift_val),
    .held      (count),
    .done      (sift_done),
    .we        (eng_we),
    .waddr     (eng_waddr),
    .wdata     (eng_wdata),
    .raddr_a   (eng_raddr_a),
    .raddr_b   (eng_raddr_b),
    .rdata_a   (ram_rdata_a),
    .rdata_b   (ram_rdata_b)
  );

  // Sequence commands, track the root and hold the result
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      // Raise valid on a finished result, drop it once taken
      if ((state == S_FINISH) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (ram_we && (ram_waddr == '0)) begin
        root <= ram_wdata;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            cmd_q     <= cmd_in;
            removed_q <= '0;
            taken_q   <= 1'b0;
            status_q  <= bmhs_pkg::ST_OK;
            state     <= S_FINISH;
            case (cmd_in)
              bmhs_pkg::CMD_LOAD: begin
                if (full) begin
                  status_q <= bmhs_pkg::ST_FULL;
                end else begin
                  count <= count + CW'(1);
                end
              end
              bmhs_pkg::CMD_BUILD: begin
                bp <= cnt_half[AW-1:0];
                if (cnt_half != '0) begin
                  state <= S_BLD_RD;
                end
              end
              bmhs_pkg::CMD_OFFER: begin
                if (empty) begin
                  status_q <= bmhs_pkg::ST_EMPTY;
                end else if (offer_ok) begin
                  taken_q <= 1'b1;
                  state   <= S_SIFT;
                end
              end
              default: begin
                if (empty) begin
                  status_q <= bmhs_pkg::ST_EMPTY;
                end else begin
                  removed_q <= root;
                  count     <= cnt_dec;
                  if (cnt_dec != '0) begin
                    state <= S_LAST;
                  end
                end
              end
            endcase
          end
        end
        S_LAST: begin
          state <= S_SIFT;
        end
        S_BLD_RD: begin
          bp    <= bp - AW'(1);
          state <= S_BLD_USE;
        end
        S_BLD_USE: begin
          state <= S_SIFT;
        end
        S_SIFT: begin
          if (sift_done) begin
            if ((cmd_q == bmhs_pkg::CMD_BUILD) && (bp != '0)) begin
              state <= S_BLD_RD;
            end else begin
              state <= S_FINISH;
            end
          end
        end
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            top_out     <= empty ? '0 : root;
            removed_out <= removed_q;
            count_out   <= bmhs_pkg::ENTRY_W'(count);
            taken_out   <= taken_q;
            status_out  <= status_q;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign top_value     = top_out;
  assign removed_value = removed_out;
  assign entry_count   = count_out;
  assign offer_taken   = taken_out;
  assign status        = status_out;

  `BMHS_ASSERT_IMPL(a_done_in_sift, sift_done, state == S_SIFT, "sift done outside sift state")
  `BMHS_ASSERT_NEXT(a_load_count, load_ok_fire, count == $past(count) + CW'(1), "load lost count")
  `BMHS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(count_out), "result dropped while stalled")

endmodule

FILE: rtl/bmhs_ram.sv
// Generic synchronous RAM: one write port, two registered read ports.
// Depends on nothing.
module bmhs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [AW-1:0]            waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [AW-1:0]            raddr_a,
  input  logic [AW-1:0]            raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register both reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

FILE: rtl/bmhs_sift.sv
// Sift-down engine: walks one value down the heap, a read step then a compare step per level.
// Depends on bmhs_pkg and assert_macros.svh; drives the heap RAM ports.
`include "assert_macros.svh"

module bmhs_sift #(
  parameter int DEPTH = bmhs_pkg::DEPTH_DEFAULT,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [AW-1:0]         start_pos,
  input  bmhs_pkg::value_t      start_val,
  input  logic [CW-1:0]         held,
  output logic                  done,
  output logic                  we,
  output logic [AW-1:0]         waddr,
  output bmhs_pkg::value_t      wdata,
  output logic [AW-1:0]         raddr_a,
  output logic [AW-1:0]         raddr_b,
  input  bmhs_pkg::value_t      rdata_a,
  input  bmhs_pkg::value_t      rdata_b
);
  localparam int IW = AW + 1;

  typedef enum logic [1:0] {E_IDLE, E_READ, E_CMP} e_state_t;

  e_state_t         e_state;
  logic [AW-1:0]    pos;
  bmhs_pkg::value_t v;
  logic [CW-1:0]    n;
  logic [IW-1:0]    child;
  logic             has_r;

  logic [IW-1:0]    child_c;
  logic [IW-1:0]    child_r1;
  logic [IW-1:0]    n_ext;
  logic             leaf;
  logic             pick_r;
  bmhs_pkg::value_t big;
  logic [IW-1:0]    big_idx;
  logic             stop;

  // Child addresses of the current slot
  assign child_c  = {pos, 1'b0} + IW'(1);
  assign child_r1 = child_c + IW'(1);
  assign n_ext    = IW'(n);
  assign leaf     = (child_c >= n_ext);

  // Pick the larger child and decide whether the value settles here
  assign pick_r  = has_r && (rdata_b > rdata_a);
  assign big     = pick_r ? rdata_b : rdata_a;
  assign big_idx = pick_r ? (child + IW'(1)) : child;
  assign stop    = (v >= big);

  assign raddr_a = child_c[AW-1:0];
  assign raddr_b = child_r1[AW-1:0];

  // Drive the write port and completion
  always_comb begin
    we    = 1'b0;
    waddr = pos;
    wdata = v;
    done  = 1'b0;
    case (e_state)
      E_READ: begin
        if (leaf) begin
          we   = 1'b1;
          done = 1'b1;
        end
      end
      E_CMP: begin
        we = 1'b1;
        if (stop) begin
          done = 1'b1;
        end else begin
          wdata = big;
        end
      end
      default: begin
      end
    endcase
  end

  // Advance the walk
  always_ff @(posedge clk) begin
    if (rst) begin
      e_state <= E_IDLE;
    end else begin
      case (e_state)
        E_IDLE: begin
          if (start) begin
            pos     <= start_pos;
            v       <= start_val;
            n       <= held;
            e_state <= E_READ;
          end
        end
        E_READ: begin
          if (leaf) begin
            e_state <= E_IDLE;
          end else begin
            child   <= child_c;
            has_r   <= (child_r1 < n_ext);
            e_state <= E_CMP;
          end
        end
        E_CMP: begin
          if (stop) begin
            e_state <= E_IDLE;
          end else begin
            pos     <= big_idx[AW-1:0];
            e_state <= E_READ;
          end
        end
        default: begin
          e_state <= E_IDLE;
        end
      endcase
    end
  end

  `BMHS_ASSERT_IMPL(a_start_idle, start, e_state == E_IDLE, "sift start while busy")
  `BMHS_ASSERT_IMPL(a_wr_range, we, {1'b0, waddr} < n_ext, "sift write past held entries")
  `BMHS_ASSERT_NEXT(a_done_idle, done, e_state == E_IDLE, "sift not idle after done")

endmodule
